[sv/tcw_pkg.sv]
// Shared types and constants for the text console character writer.
// Holds field widths, command and operation codes, and the queued operation type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int WORD_W  = 16;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int ATTR_W  = 8;

    // Address width that covers the largest screen the parameters allow (128 x 32)
    localparam int CELL_ADDR_W = 12;

    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd47;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // Queued operation kinds
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_NONE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]             kind;
        logic [CELL_ADDR_W-1:0] addr;
        logic [CHAR_W-1:0]      ch;
        logic                   scroll;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
    } op_t;

endpackage

`default_nettype wire

[sv/text_console_char_writer_core.sv]
// Top level of the text console character writer.
// Instantiates tcw_front, tcw_fifo and tcw_back; depends on tcw_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one command item: put character,
//   read cell, clear screen, or a no-op. Every item yields exactly one result
//   item on the output channel (m_valid/m_ready) with the cell word (reads
//   only), the cursor position after the item and a scroll flag.
//   Configuration channel (cfg_valid/cfg_ready) writes the attribute byte
//   used for written and blanked cells; it is always ready and must only be
//   written while the block is idle.
//   A put or no-op item passes through the queue, and its result is loaded
//   into the result register as the back end pops it; a read also passes
//   through the registered memory read. Plain puts sustain one item per
//   cycle while the receiver keeps m_ready high. A put that scrolls and a
//   clear sweep the whole screen memory once through the single write port
//   of the screen memory, and the input stalls once the two-entry queue
//   fills.
//   Reset clears the cursor to home, the attribute to its default and empties
//   the queue and result register; the screen contents are undefined until
//   the first clear. When the receiver stalls, the result is held and the
//   back end waits, then the queue fills and s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer_core #(
    parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration write channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
    // command input
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [tcw_pkg::CMD_W-1:0]   s_cmd,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  s_char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0] s_cell_index,
    // result output
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [tcw_pkg::WORD_W-1:0]       m_cell_word,
    output logic [tcw_pkg::ROW_W-1:0]        m_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]        m_cursor_col,
    output logic                             m_did_scroll
);

    logic [tcw_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    tcw_pkg::op_t               push_op;
    tcw_pkg::op_t               head_op;

    // Attribute register: always ready, written whenever a word arrives
    assign cfg_ready = 1'b1;
    assign attr_next = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= tcw_pkg::ATTR_RESET;
        end else begin
            attr_reg <= attr_next;
        end
    end

    // Front: accept, classify, advance the cursor
    tcw_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_op         (push_op)
    );

    // Queue: decouple front stalls from long back-end sweeps
    tcw_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_op  (push_op),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_op  (head_op)
    );

    // Back: screen memory, sweeps and result register
    tcw_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .attr         (attr_reg),
        .q_empty      (q_empty),
        .q_op         (head_op),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_word  (m_cell_word),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_did_scroll (m_did_scroll)
    );

endmodule

`default_nettype wire

[sv/tcw_front.sv]
// Front end of the console writer: accepts items, tracks the cursor,
// and turns each item into a queued operation. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front #(
    parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [tcw_pkg::CMD_W-1:0]   s_cmd,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  s_char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0] s_cell_index,
    input  wire logic                        q_full,
    output logic                             q_push,
    output tcw_pkg::op_t                     q_op
);

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;

    logic [tcw_pkg::ROW_W-1:0] row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0] col_reg, col_next;
    logic                      accept;
    logic                      wrap;
    logic                      last_row;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    assign last_row = (row_reg == tcw_pkg::ROW_W'(SCREEN_HEIGHT - 1));
    assign wrap     = (s_char_code == tcw_pkg::NEWLINE_CODE)
                   || (col_reg == tcw_pkg::COL_W'(SCREEN_WIDTH - 1));

    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        q_op.kind     = tcw_pkg::KIND_NONE;
        q_op.addr     = tcw_pkg::CELL_ADDR_W'(s_cell_index);
        q_op.ch       = s_char_code;
        q_op.scroll   = 1'b0;
        unique case (s_cmd)
            tcw_pkg::CMD_PUT: begin
                // Newline writes nothing but still moves the cursor
                q_op.kind = (s_char_code == tcw_pkg::NEWLINE_CODE)
                          ? tcw_pkg::KIND_NONE : tcw_pkg::KIND_PUT;
                q_op.addr = tcw_pkg::CELL_ADDR_W'(int'(row_reg) * SCREEN_WIDTH
                                                  + int'(col_reg));
                if (wrap) begin
                    col_next = '0;
                    if (last_row) begin
                        q_op.scroll = 1'b1;
                    end else begin
                        row_next = row_reg + tcw_pkg::ROW_W'(1);
                    end
                end else begin
                    col_next = col_reg + tcw_pkg::COL_W'(1);
                end
            end
            tcw_pkg::CMD_READ: begin
                // Out-of-range reads report zero and touch nothing
                if (32'(s_cell_index) < 32'(CELL_COUNT)) begin
                    q_op.kind = tcw_pkg::KIND_READ;
                end
            end
            tcw_pkg::CMD_CLEAR: begin
                q_op.kind = tcw_pkg::KIND_CLEAR;
                row_next  = '0;
                col_next  = '0;
            end
            tcw_pkg::CMD_NONE: begin
                q_op.kind = tcw_pkg::KIND_NONE;
            end
            default: begin
                q_op.kind = tcw_pkg::KIND_NONE;
            end
        endcase
        q_op.row = row_next;
        q_op.col = col_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

[sv/tcw_fifo.sv]
// Two-entry operation queue between front and back end.
// Depends on tcw_pkg for the operation type.
`timescale 1ns / 1ps
`default_nettype none

module tcw_fifo (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire tcw_pkg::op_t push_op,
    output logic              full,
    input  wire logic         pop,
    output logic              empty,
    output tcw_pkg::op_t      head_op
);

    tcw_pkg::op_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

[sv/tcw_back.sv]
// Back end of the console writer: owns the screen memory, executes queued
// operations (write, read, scroll, clear sweeps) and holds the result register.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
    parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [tcw_pkg::ATTR_W-1:0] attr,
    input  wire logic                       q_empty,
    input  wire tcw_pkg::op_t               q_op,
    output logic                            q_pop,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [tcw_pkg::WORD_W-1:0]      m_cell_word,
    output logic [tcw_pkg::ROW_W-1:0]       m_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]       m_cursor_col,
    output logic                            m_did_scroll
);

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RDWAIT = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [tcw_pkg::WORD_W-1:0] mem [CELL_COUNT];

    logic [1:0]                 state_reg, state_next;
    logic [ADDR_W-1:0]          cnt_reg, cnt_next;
    logic                       scroll_mode_reg, scroll_mode_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic                       s1_copy_reg, s1_copy_next;
    logic [tcw_pkg::ROW_W-1:0]  pend_row_reg;
    logic [tcw_pkg::COL_W-1:0]  pend_col_reg;
    logic                       pend_scroll_reg;
    logic [tcw_pkg::WORD_W-1:0] rd_data_reg;

    logic                       m_valid_reg, m_valid_next;
    logic [tcw_pkg::WORD_W-1:0] m_word_reg, m_word_next;
    logic [tcw_pkg::ROW_W-1:0]  m_row_reg, m_row_next;
    logic [tcw_pkg::COL_W-1:0]  m_col_reg, m_col_next;
    logic                       m_scroll_reg, m_scroll_next;

    logic                       out_free;
    logic                       load;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [tcw_pkg::WORD_W-1:0] wr_data;
    logic [tcw_pkg::WORD_W-1:0] blank;
    logic                       sweep_copy;

    assign blank      = {attr, tcw_pkg::BLANK_CODE};
    assign out_free   = !m_valid_reg || m_ready;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign sweep_copy = scroll_mode_reg
                     && (cnt_reg < ADDR_W'(CELL_COUNT - SCREEN_WIDTH));

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        scroll_mode_next = scroll_mode_reg;
        s1_valid_next    = 1'b0;
        s1_copy_next     = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = ADDR_W'(q_op.addr);
        load             = 1'b0;
        m_word_next      = '0;
        m_row_next       = pend_row_reg;
        m_col_next       = pend_col_reg;
        m_scroll_next    = pend_scroll_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    m_row_next    = q_op.row;
                    m_col_next    = q_op.col;
                    m_scroll_next = q_op.scroll;
                    cnt_next      = '0;
                    unique case (q_op.kind)
                        tcw_pkg::KIND_PUT, tcw_pkg::KIND_NONE: begin
                            if (q_op.scroll) begin
                                scroll_mode_next = 1'b1;
                                state_next       = ST_SWEEP;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        tcw_pkg::KIND_READ: begin
                            rd_en      = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                        tcw_pkg::KIND_CLEAR: begin
                            scroll_mode_next = 1'b0;
                            state_next       = ST_SWEEP;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                // Hold the read data until the result slot frees up
                m_word_next = rd_data_reg;
                if (out_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                // Read one row ahead, write back in the following cycle
                rd_en         = sweep_copy;
                rd_addr       = cnt_reg + ADDR_W'(SCREEN_WIDTH);
                s1_valid_next = 1'b1;
                s1_copy_next  = sweep_copy;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Single write port: sweep pipeline has priority, puts only issue from idle
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(q_op.addr);
        wr_data = {attr, q_op.ch};
        if (s1_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = s1_addr_reg;
            wr_data = s1_copy_reg ? rd_data_reg : blank;
        end else if (q_pop && (q_op.kind == tcw_pkg::KIND_PUT)) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg         <= cnt_next;
        scroll_mode_reg <= scroll_mode_next;
        s1_addr_reg     <= cnt_reg;
        s1_copy_reg     <= s1_copy_next;
        if (q_pop) begin
            pend_row_reg    <= q_op.row;
            pend_col_reg    <= q_op.col;
            pend_scroll_reg <= q_op.scroll;
        end
        if (load) begin
            m_word_reg   <= m_word_next;
            m_row_reg    <= m_row_next;
            m_col_reg    <= m_col_next;
            m_scroll_reg <= m_scroll_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_word  = m_word_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cursor_col = m_col_reg;
    assign m_did_scroll = m_scroll_reg;

endmodule

`default_nettype wire
